/* rtl/core/drs_pkg.sv */
package drs_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam int VCFG_W  = 7;
    localparam int VTX_W   = 6;
    localparam int CNT_W   = 9;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam logic [VCFG_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE   = 2'd0,
        OP_NEW_SEARCH = 2'd1,
        OP_CONT_SEARCH = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_WALK_INIT,
        S_WALK_TOP,
        S_WALK_EDGE,
        S_WALK_HEAD,
        S_REPORT_RD,
        S_REPORT,
        S_OUT
    } state_t;

endpackage

/* rtl/core/drs_if.sv */
interface drs_in_if;
    import drs_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [VTX_W-1:0]    vertex_a;
    logic [VTX_W-1:0]    vertex_b;
    modport source (output valid, operation, vertex_a, vertex_b, input ready);
    modport sink   (input valid, operation, vertex_a, vertex_b, output ready);
endinterface

interface drs_out_if;
    import drs_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic                reached;
    logic [CNT_W-1:0]    in_degree;
    logic [CNT_W-1:0]    out_degree;
    logic [CNT_W-1:0]    total_edges;
    modport source (output valid, status, reached, in_degree, out_degree, total_edges,
                    input ready);
    modport sink   (input valid, status, reached, in_degree, out_degree, total_edges,
                    output ready);
endinterface

interface drs_cfg_if;
    import drs_pkg::*;
    logic                valid;
    logic                ready;
    logic [VCFG_W-1:0]   vertex_count;
    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

/* rtl/core/digraph_reachability_search.sv */
// Directed-graph reachability engine with adjacency chains in an edge memory.
// Channels: cfg writes vertex_count and is ready only while the block is idle.
// in carries operation, vertex_a and vertex_b; out returns one item per input
// item with status, mark and degrees of vertex_a and the total edge count.
// Only one item is in work at a time; in.ready is low from acceptance until
// the result has been taken by the receiver.
// From acceptance, a stored edge passes S_ADD_RD, S_ADD_WR, S_REPORT_RD and
// S_REPORT before out.valid; a read, a rejected item or a continued search
// from an already marked source skips S_ADD_WR. Other searches go from S_ADD_RD
// to S_WALK_INIT and then S_WALK_TOP, S_WALK_EDGE and S_WALK_HEAD per edge
// scanned, in the single walk sequencer over the edge and vertex memories.
// A new search clears all marks but its source's at once (marks are flip-flops).
// Reset clears marks, degree counts, chain heads (through valid bits) and the
// edge count at once; no clearing pass is needed. The edge store and walk
// stack hold no reset value. When the receiver stalls, the result is held in
// the output register and no new item is accepted.
module digraph_reachability_search #(
    parameter int MAX_VERTICES = drs_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = drs_pkg::DEF_MAX_EDGES
)(
    input  logic clk,
    input  logic rst_n,
    drs_cfg_if.sink cfg,
    drs_in_if.sink  in,
    drs_out_if.source out
);
    import drs_pkg::*;

    localparam int VA_W = $clog2(MAX_VERTICES);
    localparam int EA_W = $clog2(MAX_EDGES);
    localparam int LK_W = $clog2(MAX_EDGES + 1);
    localparam int ET_W = $clog2(MAX_EDGES + 1);
    localparam int SP_W = $clog2(MAX_VERTICES + 1);
    localparam logic [LK_W-1:0] NULL_LK = LK_W'(MAX_EDGES);

    // Memories.
    logic [VTX_W-1:0] edge_target_mem [MAX_EDGES];
    logic [LK_W-1:0]  edge_next_mem   [MAX_EDGES];
    logic [LK_W-1:0]  head_mem        [MAX_VERTICES];
    logic [ET_W-1:0]  in_cnt_mem      [MAX_VERTICES];
    logic [ET_W-1:0]  out_cnt_mem     [MAX_VERTICES];
    logic [LK_W-1:0]  stk_lnk_mem     [MAX_VERTICES];
    // head_ok_reg covers the chain head and the out count of a vertex,
    // in_ok_reg its in count.
    logic [MAX_VERTICES-1:0] head_ok_reg;
    logic [MAX_VERTICES-1:0] in_ok_reg;
    logic [MAX_VERTICES-1:0] mark_reg;

    state_t state_reg, state_next;
    logic [VCFG_W-1:0] vcount_reg;
    logic [ET_W-1:0]   edge_total_reg;
    logic [OP_W-1:0]   op_reg;
    logic [VTX_W-1:0]  a_reg, b_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [LK_W-1:0]   lnk_reg;      // link of the stack top
    logic [VA_W-1:0]   tgt_reg;
    logic [STAT_W-1:0] status_reg;

    // Registered read data.
    logic [LK_W-1:0]  head_rd_reg;
    logic [ET_W-1:0]  in_rd_reg, out_rd_reg;
    logic [VTX_W-1:0] et_rd_reg;
    logic [LK_W-1:0]  en_rd_reg;
    logic [LK_W-1:0]  sl_rd_reg;
    logic             head_ok_rd_reg, in_ok_rd_reg;

    // Shared address for vertex memories.
    logic [VA_W-1:0] vaddr;
    logic [VA_W-1:0] a_v, b_v;
    logic            a_ok, b_ok;
    logic [VCFG_W:0] nv;
    logic [MAX_VERTICES-1:0] a_mask;

    assign a_v = VA_W'(a_reg);
    assign b_v = VA_W'(b_reg);
    assign nv  = (vcount_reg > VCFG_W'(MAX_VERTICES)) ? (VCFG_W+1)'(MAX_VERTICES)
                                                      : {1'b0, vcount_reg};
    assign a_ok = {{(VCFG_W+1-VTX_W){1'b0}}, a_reg} < nv;
    assign b_ok = {{(VCFG_W+1-VTX_W){1'b0}}, b_reg} < nv;
    assign a_mask = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_v;

    logic [STAT_W-1:0] out_status_reg;
    logic              out_reached_reg;
    logic [CNT_W-1:0]  out_in_reg, out_out_reg, out_tot_reg;

    assign cfg.ready = (state_reg == S_IDLE);
    assign in.ready  = (state_reg == S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.status      = out_status_reg;
    assign out.reached     = out_reached_reg;
    assign out.in_degree   = out_in_reg;
    assign out.out_degree  = out_out_reg;
    assign out.total_edges = out_tot_reg;

    always_comb
    begin
        state_next = state_reg;
        vaddr = a_v;
        case (state_reg)
            S_IDLE:      if (in.valid) state_next = S_ADD_RD;
            S_ADD_RD:
            begin
                if (!a_ok || (op_reg == OP_ADD_EDGE && !b_ok))
                    state_next = S_REPORT_RD;
                else if (op_reg == OP_ADD_EDGE)
                    state_next = (edge_total_reg >= ET_W'(MAX_EDGES)) ? S_REPORT_RD
                                                                       : S_ADD_WR;
                else if (op_reg == OP_NEW_SEARCH)
                    state_next = S_WALK_INIT;
                else if (op_reg == OP_CONT_SEARCH && !mark_reg[a_v])
                    state_next = S_WALK_INIT;
                else
                    state_next = S_REPORT_RD;
            end
            S_ADD_WR:    state_next = S_REPORT_RD;
            S_WALK_INIT: state_next = S_WALK_TOP;
            S_WALK_TOP:
            begin
                if (sp_reg == '0)
                    state_next = S_REPORT_RD;
                else if (lnk_reg >= NULL_LK)
                    state_next = S_WALK_TOP;
                else
                    state_next = S_WALK_EDGE;
            end
            S_WALK_EDGE:
            begin
                vaddr = VA_W'(et_rd_reg);
                state_next = S_WALK_HEAD;
            end
            S_WALK_HEAD: state_next = S_WALK_TOP;
            S_REPORT_RD: state_next = S_REPORT;
            S_REPORT:    state_next = S_OUT;
            S_OUT:       if (out.ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Vertex memory reads (registered).
    always_ff @(posedge clk)
    begin
        head_rd_reg    <= head_mem[vaddr];
        in_rd_reg      <= in_cnt_mem[vaddr];
        out_rd_reg     <= out_cnt_mem[vaddr];
        head_ok_rd_reg <= head_ok_reg[vaddr];
        in_ok_rd_reg   <= in_ok_reg[vaddr];
    end

    // Edge memory: read at the stack top link, written on add edge.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD_WR)
        begin
            edge_target_mem[EA_W'(edge_total_reg)] <= b_reg;
            edge_next_mem[EA_W'(edge_total_reg)]   <= head_ok_rd_reg ? head_rd_reg : NULL_LK;
        end
        et_rd_reg <= edge_target_mem[EA_W'(lnk_reg)];
        en_rd_reg <= edge_next_mem[EA_W'(lnk_reg)];
    end

    // The in count of vertex_b comes through a second read port.
    logic [ET_W-1:0] in_b_rd_reg;
    logic            in_b_ok_reg;
    always_ff @(posedge clk)
    begin
        in_b_rd_reg <= in_cnt_mem[b_v];
        in_b_ok_reg <= in_ok_reg[b_v];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD_WR)
        begin
            head_mem[a_v]    <= LK_W'(edge_total_reg);
            out_cnt_mem[a_v] <= (head_ok_rd_reg ? out_rd_reg : '0) + ET_W'(1);
            in_cnt_mem[b_v]  <= (in_b_ok_reg ? in_b_rd_reg : '0) + ET_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ok_reg <= '0;
            in_ok_reg   <= '0;
        end
        else if (state_reg == S_ADD_WR)
        begin
            head_ok_reg[a_v] <= 1'b1;
            in_ok_reg[b_v]   <= 1'b1;
        end
    end

    // Walk stack: the top entry's link lives in lnk_reg; the rest in memory.
    logic [SP_W-1:0] sp_m1;
    assign sp_m1 = sp_reg - SP_W'(1);
    always_ff @(posedge clk)
    begin
        sl_rd_reg <= stk_lnk_mem[VA_W'(sp_reg - SP_W'(2))];
        if (state_reg == S_WALK_HEAD && sp_reg != '0)
            stk_lnk_mem[VA_W'(sp_m1)] <= lnk_reg;
    end

    // sl_rd_reg gives the link beneath the top; it is read in the cycle the
    // top pops, so a further TOP visit after the pop restores the link.
    logic pop_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= VCOUNT_RESET;
            edge_total_reg <= '0;
            mark_reg       <= '0;
            sp_reg         <= '0;
            pop_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                vcount_reg <= cfg.vertex_count;
            case (state_reg)
                S_ADD_WR: edge_total_reg <= edge_total_reg + ET_W'(1);
                S_WALK_INIT:
                begin
                    if (op_reg == OP_NEW_SEARCH)
                        mark_reg <= a_mask;
                    else
                        mark_reg <= mark_reg | a_mask;
                    sp_reg <= SP_W'(1);
                    pop_pending_reg <= 1'b0;
                end
                S_WALK_TOP:
                begin
                    if (pop_pending_reg)
                        pop_pending_reg <= 1'b0;
                    else if (sp_reg != '0 && lnk_reg >= NULL_LK)
                    begin
                        sp_reg <= sp_m1;
                        pop_pending_reg <= 1'b1;
                    end
                end
                S_WALK_HEAD:
                begin
                    if (!mark_reg[tgt_reg])
                    begin
                        mark_reg[tgt_reg] <= 1'b1;
                        if (sp_reg < SP_W'(MAX_VERTICES))
                            sp_reg <= sp_reg + SP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in.valid)
        begin
            op_reg <= in.operation;
            a_reg  <= in.vertex_a;
            b_reg  <= in.vertex_b;
        end
        case (state_reg)
            S_WALK_INIT: lnk_reg <= head_ok_rd_reg ? head_rd_reg : NULL_LK;
            S_WALK_TOP:  if (pop_pending_reg) lnk_reg <= sl_rd_reg;
            S_WALK_EDGE:
            begin
                tgt_reg <= VA_W'(et_rd_reg);
                lnk_reg <= en_rd_reg;
            end
            S_WALK_HEAD:
                if (!mark_reg[tgt_reg] && sp_reg < SP_W'(MAX_VERTICES))
                    lnk_reg <= head_ok_rd_reg ? head_rd_reg : NULL_LK;
            default: ;
        endcase
        if (state_reg == S_ADD_RD)
            status_reg <= (!a_ok || (op_reg == OP_ADD_EDGE && !b_ok)) ? ST_RANGE :
                          (op_reg == OP_ADD_EDGE && edge_total_reg >= ET_W'(MAX_EDGES))
                              ? ST_FULL : ST_OK;
        if (state_reg == S_REPORT)
        begin
            out_status_reg  <= status_reg;
            out_tot_reg     <= CNT_W'(edge_total_reg);
            if (status_reg == ST_RANGE)
            begin
                out_reached_reg <= 1'b0;
                out_in_reg      <= '0;
                out_out_reg     <= '0;
            end
            else
            begin
                out_reached_reg <= mark_reg[a_v];
                out_in_reg      <= in_ok_rd_reg ? CNT_W'(in_rd_reg) : '0;
                out_out_reg     <= head_ok_rd_reg ? CNT_W'(out_rd_reg) : '0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> !in.ready)
        else $error("accepted a second item while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.total_edges))
        else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(MAX_VERTICES))
        else $error("walk stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ET_W'(MAX_EDGES))
        else $error("edge count beyond store");

endmodule

/* tb/drs_tb_checker.sv */
module drs_tb_checker (
    input  logic clk,
    input  logic rst_n,
    drs_cfg_if.sink  cfg,
    drs_in_if.sink   in,
    drs_out_if.sink  out,
    output int       fail_count,
    output int       pending
);
    import drs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            status;
        logic               reached;
        logic [CNT_W-1:0]   in_degree;
        logic [CNT_W-1:0]   out_degree;
        logic [CNT_W-1:0]   total_edges;
    } vertex_report_t;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NE = DEF_MAX_EDGES;

    logic [VCFG_W-1:0] active_count;
    int unsigned       head_of[NV];
    int unsigned       target_of[NE];
    int unsigned       link_of[NE];
    int unsigned       indeg[NV];
    int unsigned       outdeg[NV];
    bit                mark[NV];
    int unsigned       edges;
    vertex_report_t    expected_reports[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Depth-first walk with an explicit stack of (vertex, next link) pairs.
    task automatic mark_reachable(input int unsigned src);
        int unsigned sv[NV];
        int unsigned sl[NV];
        int unsigned sp;
        int unsigned lk;
        int unsigned t;
        mark[src] = 1;
        sv[0] = src;
        sl[0] = head_of[src];
        sp = 1;
        while (sp > 0) begin
            lk = sl[sp-1];
            if (lk >= NE) begin
                sp--;
            end
            else begin
                t = target_of[lk];
                sl[sp-1] = link_of[lk];
                if (t < NV && !mark[t]) begin
                    mark[t] = 1;
                    if (sp < NV) begin
                        sv[sp] = t;
                        sl[sp] = head_of[t];
                        sp++;
                    end
                end
            end
        end
    endtask

    function automatic int unsigned usable_vertices();
        return (int'(active_count) > NV) ? NV : int'(active_count);
    endfunction

    task automatic apply_item(input op_t op, input int unsigned a, input int unsigned b);
        vertex_report_t r;
        int unsigned nv;
        nv = usable_vertices();
        r = '0;
        r.status = ST_OK;
        if (a >= nv || (op == OP_ADD_EDGE && b >= nv)) begin
            r.status = ST_RANGE;
        end
        else if (op == OP_ADD_EDGE) begin
            if (edges >= NE) begin
                r.status = ST_FULL;
            end
            else begin
                target_of[edges] = b;
                link_of[edges] = head_of[a];
                head_of[a] = edges;
                outdeg[a]++;
                indeg[b]++;
                edges++;
            end
        end
        else if (op == OP_NEW_SEARCH) begin
            foreach (mark[i]) mark[i] = 0;
            mark_reachable(a);
        end
        else if (op == OP_CONT_SEARCH) begin
            if (!mark[a]) mark_reachable(a);
        end
        if (r.status != ST_RANGE) begin
            r.reached = mark[a];
            r.in_degree = indeg[a][CNT_W-1:0];
            r.out_degree = outdeg[a][CNT_W-1:0];
        end
        r.total_edges = edges[CNT_W-1:0];
        expected_reports.push_back(r);
    endtask

    always @(posedge clk) begin
        vertex_report_t w;
        if (!rst_n) begin
            fail_count = 0;
            active_count = VCOUNT_RESET;
            edges = 0;
            expected_reports.delete();
            foreach (head_of[i]) begin
                head_of[i] = NE;
                indeg[i] = 0;
                outdeg[i] = 0;
                mark[i] = 0;
            end
            pending = 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                active_count = cfg.vertex_count;
            if (in.valid && in.ready)
                apply_item(op_t'(in.operation), 32'(in.vertex_a), 32'(in.vertex_b));
            if (out.valid && out.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end
                else begin
                    w = expected_reports.pop_front();
                    if (out.status !== w.status)
                        report_mismatch("status", int'(out.status), int'(w.status));
                    if (out.reached !== w.reached)
                        report_mismatch("reached", int'(out.reached), int'(w.reached));
                    if (out.in_degree !== w.in_degree)
                        report_mismatch("in_degree", int'(out.in_degree),
                                        int'(w.in_degree));
                    if (out.out_degree !== w.out_degree)
                        report_mismatch("out_degree", int'(out.out_degree),
                                        int'(w.out_degree));
                    if (out.total_edges !== w.total_edges)
                        report_mismatch("total_edges", int'(out.total_edges),
                                        int'(w.total_edges));
                end
            end
            pending = expected_reports.size();
        end
    end
endmodule

/* tb/tb_top.sv */
module tb_top;
    import drs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_receiver;
    int   quiet_cycles;

    drs_cfg_if cfg();
    drs_in_if  in();
    drs_out_if out();

    digraph_reachability_search dut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .in(in), .out(out));

    drs_tb_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in(in), .out(out),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || hold_receiver)
            out.ready <= 0;
        else
            out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in.valid && in.ready) || (out.valid && out.ready)
                || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_vertex_count(input logic [VCFG_W-1:0] value);
        cfg.valid <= 1;
        cfg.vertex_count <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    // valid stays high after an accepted item so that the next item can
    // follow at once; the sender drops it while idling or draining.
    task automatic offer_item(input op_t op, input logic [VTX_W-1:0] a,
                              input logic [VTX_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in.valid <= 0;
            @(posedge clk);
        end
        in.valid <= 1;
        in.operation <= op;
        in.vertex_a <= a;
        in.vertex_b <= b;
        do @(posedge clk); while (!in.ready);
    endtask

    task automatic wait_drained();
        in.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A mix biased toward edges among low vertices so searches reach far.
    task automatic random_items(input int count, input int span);
        op_t op;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_ADD_EDGE : (pick < 60) ? OP_NEW_SEARCH :
                 (pick < 75) ? OP_CONT_SEARCH : OP_READ;
            if ($urandom_range(9) == 0)
                offer_item(op, VTX_W'($urandom), VTX_W'($urandom));
            else
                offer_item(op, VTX_W'($urandom_range(span - 1)),
                           VTX_W'($urandom_range(span - 1)));
        end
    endtask

    initial begin
        cfg.valid = 0;
        cfg.vertex_count = VCOUNT_RESET;
        in.valid = 0;
        in.operation = OP_READ;
        in.vertex_a = 0;
        in.vertex_b = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_receiver = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reads at reset, a small cycle, out-of-range, extremes.
        offer_item(OP_READ, 0, 0);
        offer_item(OP_READ, 63, 63);
        offer_item(OP_ADD_EDGE, 0, 1);
        offer_item(OP_ADD_EDGE, 1, 2);
        offer_item(OP_ADD_EDGE, 2, 0);
        offer_item(OP_ADD_EDGE, 63, 63);
        offer_item(OP_ADD_EDGE, 3, 3);
        offer_item(OP_NEW_SEARCH, 0, 0);
        offer_item(OP_READ, 2, 0);
        offer_item(OP_CONT_SEARCH, 1, 0);
        offer_item(OP_CONT_SEARCH, 63, 0);
        offer_item(OP_READ, 3, 0);
        offer_item(OP_NEW_SEARCH, 3, 0);
        offer_item(OP_READ, 0, 0);
        wait_drained();
        write_vertex_count(4);
        offer_item(OP_ADD_EDGE, 5, 1);
        offer_item(OP_ADD_EDGE, 1, 5);
        offer_item(OP_READ, 4, 0);
        offer_item(OP_NEW_SEARCH, 2, 0);
        offer_item(OP_NEW_SEARCH, 63, 0);
        offer_item(OP_CONT_SEARCH, 3, 0);
        wait_drained();
        write_vertex_count(0);
        offer_item(OP_READ, 0, 0);
        offer_item(OP_ADD_EDGE, 0, 0);
        wait_drained();
        write_vertex_count(127);

        send_idle_pct = 6;
        recv_idle_pct = 60;
        random_items(200, 16);
        wait_drained();
        write_vertex_count(1);
        random_items(30, 2);

        // Long receiver hold while the sender keeps offering items.
        wait_drained();
        write_vertex_count(64);
        send_idle_pct = 60;
        recv_idle_pct = 6;
        hold_receiver = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_receiver = 0;
            end
            begin
                random_items(10, 64);
                in.valid <= 0;
                @(posedge clk);
            end
        join
        random_items(250, 64);
        wait_drained();
        write_vertex_count(VCFG_W'($urandom_range(2, 63)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(200, 64);
        wait_drained();
        write_vertex_count(64);
        // Fill the edge store past its end to see the full status.
        for (int i = 0; i < 256; i++)
            offer_item($urandom_range(3) == 0 ? OP_NEW_SEARCH : OP_ADD_EDGE,
                       VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)));

        wait_drained();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/drs_pkg.sv
rtl/core/drs_if.sv
rtl/core/digraph_reachability_search.sv
tb/drs_tb_checker.sv
tb/tb_top.sv
